// File: hdl/spr_pkg.sv
// Shared types and constants for the bounded stack with remove-by-value.
// Used by every module of the block; depends on nothing else.

package spr_pkg;

    localparam int DEPTH         = 16;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int LIMIT_W       = 5;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 8;
    localparam int CMP_W         = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        CMD_PUSH   = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // Per-cell controls: entry holds live data, take the operand, take the upper neighbor.
    typedef struct packed {
        logic valid;
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// File: hdl/spr_cell.sv
// One stack cell: holds a single entry and compares it with the operand.
// Depends on spr_pkg.

module spr_cell
    import spr_pkg::*;
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic [VALUE_W-1:0] operand,
    input  logic [VALUE_W-1:0] up_entry,
    output logic [VALUE_W-1:0] entry,
    output logic               match
);

    logic [VALUE_W-1:0] entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= operand;
        end
        else if (ctl.shift)
        begin
            entry_reg <= up_entry;
        end
    end

    assign entry = entry_reg;
    assign match = ctl.valid && (entry_reg == operand);

endmodule

// File: hdl/spr_ctrl.sv
// Command sequencer: count, limit register, per-cell controls and the result register.
// Depends on spr_pkg.

module spr_ctrl
    import spr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_command,
    input  logic [VALUE_W-1:0]       in_value,
    input  logic                     cfg_we,
    input  logic [LIMIT_W-1:0]       cfg_wdata,
    input  logic [DEPTH-1:0]         match,
    output cell_ctl_t                ctl [DEPTH],
    output logic [VALUE_W-1:0]       operand,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [ENTRY_COUNT_W-1:0] entry_count
);

    typedef enum logic {
        IDLE,
        SEARCH
    } state_t;

    state_t                   state_reg;
    cmd_t                     cmd_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [LIMIT_W-1:0]       limit_reg;
    logic                     out_valid_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                     commit;
    logic                     full;
    logic                     found;
    logic [DEPTH-1:0]         above;

    assign commit = (state_reg == SEARCH) && (!out_valid_reg || out_ready);
    assign full   = (CMP_W'(count_reg) >= CMP_W'(limit_reg))
                 || (CMP_W'(count_reg) >= CMP_W'(DEPTH));
    assign found  = |match;

    // A cell shifts when it sits at or above the topmost match, i.e. no match lies above it.
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            above[j] = |(match >> (j + 1));
        end
    end

    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            ctl[j].valid = CNT_W'(j) < count_reg;
            ctl[j].load  = commit && (cmd_reg == CMD_PUSH) && !full
                        && (count_reg == CNT_W'(j));
            ctl[j].shift = commit && (cmd_reg == CMD_REMOVE) && found && !above[j];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        unique case (cmd_reg)
            CMD_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                priority if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            cmd_reg         <= CMD_PUSH;
            value_reg       <= '0;
            count_reg       <= '0;
            limit_reg       <= LIMIT_RESET;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_DONE;
            entry_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            // A commit refills the result register in the same cycle it is taken.
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd_t'(in_command);
                        value_reg <= in_value;
                        state_reg <= SEARCH;
                    end
                end
                SEARCH:
                begin
                    if (commit)
                    begin
                        count_reg       <= count_next;
                        status_reg      <= status_next;
                        entry_count_reg <= ENTRY_COUNT_W'(count_next);
                        state_reg       <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == IDLE);
    assign operand     = value_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    logic [DEPTH-1:0] load_vec;
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            load_vec[j] = ctl[j].load;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == SEARCH))
        else $error("accepted word did not start a search");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (cmd_reg == CMD_PUSH) && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not raise the count");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_vec))
        else $error("more than one cell loaded on a push");

    a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("result register not filled after commit");

endmodule

// File: hdl/stack_push_remove_by_value.sv
// Top level of the bounded stack with push and remove-by-value.
// Depends on spr_pkg, spr_cell and spr_ctrl.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata: command, value
//  m_axis    out        tvalid/tready          tdata: status, entry_count
//  cfg       in         we (no wait)           wdata: stack_limit
//
// Each word passes two states: IDLE captures it; in SEARCH every cell compares its
// entry with the value, the topmost match is found and the cells shift or load.
// A new word is accepted only in IDLE, once the previous one has committed.
// A result waits in the output register; the next word is captured meanwhile, and
// its commit waits only while that register is still full.
// After reset the stack is empty and the limit is 16.

module stack_push_remove_by_value
    import spr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] command, [32:1] value, rest zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] status, [6:2] entry_count, [7] zero
    input  logic                   cfg_we,
    input  logic [LIMIT_W-1:0]     cfg_wdata
);

    cell_ctl_t                ctl [DEPTH];
    logic [VALUE_W-1:0]       operand;
    logic [VALUE_W-1:0]       entries [DEPTH];
    logic [DEPTH-1:0]         match;
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_COUNT_W-1:0] entry_count;

    spr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_command  (s_axis_tdata[0]),
        .in_value    (s_axis_tdata[VALUE_W:1]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .match       (match),
        .ctl         (ctl),
        .operand     (operand),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .entry_count (entry_count)
    );

    // Each cell takes its upper neighbor's entry on a shift; the top cell recirculates.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spr_cell u_cell (
            .clk      (clk),
            .ctl      (ctl[i]),
            .operand  (operand),
            .up_entry ((i == DEPTH - 1) ? entries[i] : entries[(i + 1) % DEPTH]),
            .entry    (entries[i]),
            .match    (match[i])
        );
    end

    assign m_axis_tdata = OUT_TDATA_W'({entry_count, status});

endmodule
